>>> rtl/mst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg
// Types, codes and defaults shared by the spanning tree engine modules.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int MAX_VERTICES_DEF = 16;
	localparam int WEIGHT_BITS_DEF  = 16;
	localparam int SUM_BITS         = 22;
	localparam logic [SUM_BITS-1:0] SUM_MAX = 22'h3FFFFF;
	localparam logic [4:0] VCOUNT_RESET = 5'd16;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_RUN   = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  vertex_u;
		logic [4:0]  vertex_v;
		logic [15:0] edge_weight;
	} in_t;

	typedef struct packed {
		logic        is_edge;
		logic [4:0]  from_vertex;
		logic [4:0]  to_vertex;
		logic [15:0] chosen_weight;
		logic [21:0] total_weight;
		logic        spanning;
		logic        last;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_ADD_REV,
		S_CHECK,
		S_SCAN,
		S_DRAIN,
		S_TEST,
		S_WALK_A,
		S_WALK_B,
		S_EMIT,
		S_SUMMARY
	} state_t;

	typedef struct packed {
		logic latch;
		logic do_clear;
		logic wr_fwd;
		logic wr_rev;
		logic run_init;
		logic scan_start;
		logic scan_step;
		logic walk_load_a;
		logic walk_load_b;
		logic walk_step;
		logic save_ra;
		logic do_union;
		logic remove_edge;
		logic load_edge_out;
		logic load_sum_out;
	} ctl_t;

	typedef struct packed {
		cmd_code_t code;
		logic      endpoints_ok;
		logic      scan_last;
		logic      found;
		logic      at_root;
		logic      roots_differ;
		logic      more_edges;
		logic      out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> rtl/mst_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_ctrl
// Sequencer for command decode, matrix scan, root walks and result beats.
// ----------------------------------------------------------------------------
module mst_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cmd_valid,
	output logic                cmd_ready,
	input  wire mst_pkg::sts_t  sts,
	output mst_pkg::ctl_t       ctl
);

	mst_pkg::state_t state_q;
	mst_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mst_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			mst_pkg::S_IDLE: begin
				if (cmd_valid) state_nxt = mst_pkg::S_DECODE;
			end
			mst_pkg::S_DECODE: begin
				case (sts.code)
					mst_pkg::CMD_ADD: begin
						state_nxt = sts.endpoints_ok ? mst_pkg::S_ADD_REV : mst_pkg::S_IDLE;
					end
					mst_pkg::CMD_RUN: state_nxt = mst_pkg::S_CHECK;
					default:          state_nxt = mst_pkg::S_IDLE;
				endcase
			end
			mst_pkg::S_ADD_REV: state_nxt = mst_pkg::S_IDLE;
			mst_pkg::S_CHECK: begin
				state_nxt = sts.more_edges ? mst_pkg::S_SCAN : mst_pkg::S_SUMMARY;
			end
			mst_pkg::S_SCAN: begin
				if (sts.scan_last) state_nxt = mst_pkg::S_DRAIN;
			end
			mst_pkg::S_DRAIN: state_nxt = mst_pkg::S_TEST;
			mst_pkg::S_TEST: begin
				state_nxt = sts.found ? mst_pkg::S_WALK_A : mst_pkg::S_SUMMARY;
			end
			mst_pkg::S_WALK_A: begin
				if (sts.at_root) state_nxt = mst_pkg::S_WALK_B;
			end
			mst_pkg::S_WALK_B: begin
				if (sts.at_root) begin
					state_nxt = sts.roots_differ ? mst_pkg::S_EMIT : mst_pkg::S_CHECK;
				end
			end
			mst_pkg::S_EMIT: begin
				if (sts.out_free) state_nxt = mst_pkg::S_CHECK;
			end
			mst_pkg::S_SUMMARY: begin
				if (sts.out_free) state_nxt = mst_pkg::S_IDLE;
			end
			default: state_nxt = mst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_ready = 1'b0;
		case (state_q)
			mst_pkg::S_IDLE: begin
				cmd_ready = 1'b1;
				ctl.latch = cmd_valid;
			end
			mst_pkg::S_DECODE: begin
				ctl.do_clear = (sts.code == mst_pkg::CMD_CLEAR);
				ctl.wr_fwd   = (sts.code == mst_pkg::CMD_ADD) && sts.endpoints_ok;
				ctl.run_init = (sts.code == mst_pkg::CMD_RUN);
			end
			mst_pkg::S_ADD_REV: ctl.wr_rev = 1'b1;
			mst_pkg::S_CHECK:   ctl.scan_start = sts.more_edges;
			mst_pkg::S_SCAN:    ctl.scan_step = 1'b1;
			mst_pkg::S_TEST:    ctl.walk_load_a = sts.found;
			mst_pkg::S_WALK_A: begin
				ctl.save_ra     = sts.at_root;
				ctl.walk_load_b = sts.at_root;
				ctl.walk_step   = !sts.at_root;
			end
			mst_pkg::S_WALK_B: begin
				ctl.remove_edge = sts.at_root;
				ctl.do_union    = sts.at_root && sts.roots_differ;
				ctl.walk_step   = !sts.at_root;
			end
			mst_pkg::S_EMIT:    ctl.load_edge_out = sts.out_free;
			mst_pkg::S_SUMMARY: ctl.load_sum_out = sts.out_free;
			default: ctl = '0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/mst_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mst_dp
// Cost memory, present bits, parent forest, scan pipeline and result register.
// ----------------------------------------------------------------------------
module mst_dp #(
	parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire mst_pkg::in_t  cmd_data,
	input  wire logic          cfg_valid,
	input  wire logic [4:0]    cfg_data,
	output logic               res_valid,
	input  wire logic          res_ready,
	output mst_pkg::out_t      res_data,
	input  wire mst_pkg::ctl_t ctl,
	output mst_pkg::sts_t      sts
);

	localparam int VW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW    = $clog2(MAX_VERTICES + 1);
	localparam int PW    = VW + 1;
	localparam int AW    = 2 * VW;
	localparam int DEPTH = 1 << AW;
	localparam int XW    = 33;

	logic [4:0]             vcount_q;
	logic [CW-1:0]          n_eff;
	mst_pkg::in_t           lat_q;
	logic [WEIGHT_BITS-1:0] wm [DEPTH];
	logic [WEIGHT_BITS-1:0] rdata_s1;
	logic [DEPTH-1:0]       present_q;
	logic [PW-1:0]          parent_q [MAX_VERTICES];
	logic [VW-1:0]          row_q, col_q;
	logic                   valid_s1, present_s1;
	logic [VW-1:0]          row_s1, col_s1;
	logic                   found_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic [VW-1:0]          a_q, b_q, x_q, ra_q;
	logic [CW-1:0]          edges_q;
	logic [mst_pkg::SUM_BITS-1:0] sum_q;
	logic [XW-1:0]          sum_ext;
	logic [VW-1:0]          u0, v0;
	logic [AW-1:0]          waddr, raddr;
	logic                   res_valid_q;
	mst_pkg::out_t          res_q;
	logic                   better;

	always_comb begin
		if (vcount_q == 5'd0) n_eff = CW'(1);
		else if (8'(vcount_q) > 8'(MAX_VERTICES)) n_eff = CW'(MAX_VERTICES);
		else n_eff = CW'(vcount_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= mst_pkg::VCOUNT_RESET;
		end else if (cfg_valid) begin
			vcount_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.latch) lat_q <= cmd_data;
	end

	assign u0    = VW'(lat_q.vertex_u - 5'd1);
	assign v0    = VW'(lat_q.vertex_v - 5'd1);
	assign waddr = ctl.wr_fwd ? {u0, v0} : {v0, u0};
	assign raddr = {row_q, col_q};

	always_ff @(posedge clk) begin
		if (ctl.wr_fwd || ctl.wr_rev) wm[waddr] <= WEIGHT_BITS'(lat_q.edge_weight);
		rdata_s1 <= wm[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
		end else if (ctl.do_clear) begin
			present_q <= '0;
		end else if (ctl.wr_fwd || ctl.wr_rev) begin
			present_q[waddr] <= 1'b1;
		end else if (ctl.remove_edge) begin
			present_q[{a_q, b_q}] <= 1'b0;
			present_q[{b_q, a_q}] <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) parent_q[k] <= '0;
		end else if (ctl.do_clear || ctl.run_init) begin
			for (int k = 0; k < MAX_VERTICES; k++) parent_q[k] <= '0;
		end else if (ctl.do_union) begin
			parent_q[x_q] <= PW'(ra_q) + PW'(1);
		end
	end

	// scan address and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			valid_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			valid_s1 <= ctl.scan_step;
			if (ctl.scan_start) begin
				row_q   <= '0;
				col_q   <= '0;
				found_q <= 1'b0;
			end else if (ctl.scan_step) begin
				if (CW'(col_q) == n_eff - CW'(1)) begin
					col_q <= '0;
					row_q <= row_q + VW'(1);
				end else begin
					col_q <= col_q + VW'(1);
				end
			end
			if (better) found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		present_s1 <= present_q[raddr];
		row_s1     <= row_q;
		col_s1     <= col_q;
	end

	assign better = valid_s1 && present_s1 && (!found_q || rdata_s1 < best_q);

	always_ff @(posedge clk) begin
		if (better) begin
			best_q <= rdata_s1;
			a_q    <= row_s1;
			b_q    <= col_s1;
		end
	end

	// root walks
	always_ff @(posedge clk) begin
		if (ctl.walk_load_a) x_q <= a_q;
		else if (ctl.walk_load_b) x_q <= b_q;
		else if (ctl.walk_step) x_q <= VW'(parent_q[x_q] - PW'(1));
		if (ctl.save_ra) ra_q <= x_q;
	end

	assign sum_ext = XW'(sum_q) + XW'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edges_q <= '0;
			sum_q   <= '0;
		end else if (ctl.do_clear || ctl.run_init) begin
			edges_q <= '0;
			sum_q   <= '0;
		end else if (ctl.do_union) begin
			edges_q <= edges_q + CW'(1);
			sum_q   <= (sum_ext > XW'(mst_pkg::SUM_MAX)) ? mst_pkg::SUM_MAX
			           : sum_ext[mst_pkg::SUM_BITS-1:0];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.load_edge_out || ctl.load_sum_out) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_edge_out) begin
			res_q.is_edge       <= 1'b1;
			res_q.from_vertex   <= 5'(PW'(a_q) + PW'(1));
			res_q.to_vertex     <= 5'(PW'(b_q) + PW'(1));
			res_q.chosen_weight <= 16'(best_q);
			res_q.total_weight  <= sum_q;
			res_q.spanning      <= 1'b0;
			res_q.last          <= 1'b0;
		end else if (ctl.load_sum_out) begin
			res_q.is_edge       <= 1'b0;
			res_q.from_vertex   <= '0;
			res_q.to_vertex     <= '0;
			res_q.chosen_weight <= '0;
			res_q.total_weight  <= sum_q;
			res_q.spanning      <= (edges_q == n_eff - CW'(1));
			res_q.last          <= 1'b1;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_comb begin
		sts.code         = mst_pkg::cmd_code_t'(lat_q.command);
		sts.endpoints_ok = (lat_q.vertex_u != 5'd0) && (lat_q.vertex_v != 5'd0)
		                   && (8'(lat_q.vertex_u) <= 8'(n_eff))
		                   && (8'(lat_q.vertex_v) <= 8'(n_eff));
		sts.scan_last    = (CW'(row_q) == n_eff - CW'(1)) && (CW'(col_q) == n_eff - CW'(1));
		sts.found        = found_q;
		sts.at_root      = (parent_q[x_q] == '0);
		sts.roots_differ = (ra_q != x_q);
		sts.more_edges   = (edges_q < n_eff - CW'(1));
		sts.out_free     = !res_valid_q || res_ready;
	end

endmodule
`default_nettype wire

>>> rtl/minimum_spanning_tree_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// minimum_spanning_tree_engine
// Kruskal spanning tree over a symmetric cost matrix with clear/add/run beats.
// ----------------------------------------------------------------------------
// channel  signals                         beat
// cmd      cmd_valid cmd_ready cmd_data    one command in
// res      res_valid res_ready res_data    one tree edge or run summary out
// cfg      cfg_valid cfg_ready cfg_data    vertex_count write
//
// clear and ignored commands pass decode only; add-edge adds a reverse write
// run: each pick is one row-major scan of n*n cost memory reads, drain and test,
//   a parent walk per endpoint and an emit when the roots differ; up to one pick
//   per present edge, n-1 when every pick joins two trees
// reset clears present bits, forest and counters; no clearing pass
// a stalled result holds the sequencer; a new command is taken once the run
//   has loaded its summary
// ----------------------------------------------------------------------------
module minimum_spanning_tree_engine #(
	parameter int MAX_VERTICES = mst_pkg::MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = mst_pkg::WEIGHT_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cmd_valid,
	output logic              cmd_ready,
	input  wire mst_pkg::in_t cmd_data,
	output logic              res_valid,
	input  wire logic         res_ready,
	output mst_pkg::out_t     res_data,
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [4:0]   cfg_data
);

	mst_pkg::ctl_t ctl;
	mst_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	mst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	mst_dp #(
		.MAX_VERTICES (MAX_VERTICES),
		.WEIGHT_BITS  (WEIGHT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the spanning tree engine. Commands go in as beats
// in random bursts; every accepted command updates a local copy of the cost
// matrix and forest, and the predicted tree edges and summaries are checked
// beat by beat against the result channel under random back-pressure.
// ----------------------------------------------------------------------------
module tb;

	localparam int NV = 16;
	localparam int LIMIT = 2000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	mst_pkg::in_t cmd_data = '0;
	logic res_valid;
	logic res_ready = 1'b0;
	mst_pkg::out_t res_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [4:0] cfg_data = '0;

	always #5 clk = ~clk;

	minimum_spanning_tree_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	logic [15:0]   cost_mem [0:NV*NV-1];
	logic          edge_on [0:NV*NV-1];
	logic [4:0]    forest [0:NV];
	logic [4:0]    vcount = mst_pkg::VCOUNT_RESET;
	mst_pkg::out_t tree_q [$];
	int            mismatches = 0;
	int            cycles = 0;
	int            burst_left = 0;
	bit            hold_req = 0;

	function automatic int eff_n();
		if (vcount < 1) return 1;
		if (vcount > NV) return NV;
		return int'(vcount);
	endfunction

	function automatic int root_of(int x);
		int steps;
		steps = 0;
		while (x <= NV && forest[x] != 0 && steps <= NV) begin
			x = int'(forest[x]);
			steps++;
		end
		return x;
	endfunction

	task automatic predict_tree(input mst_pkg::in_t it);
		int n, chosen, best, a, b, ra, rb, idx;
		logic [21:0] total;
		bit found;
		mst_pkg::out_t r;
		n = eff_n();
		case (mst_pkg::cmd_code_t'(it.command))
			mst_pkg::CMD_CLEAR: begin
				for (int k = 0; k < NV*NV; k++) edge_on[k] = 1'b0;
				for (int k = 0; k <= NV; k++) forest[k] = '0;
			end
			mst_pkg::CMD_ADD: begin
				if (it.vertex_u >= 1 && it.vertex_v >= 1 && it.vertex_u <= n
						&& it.vertex_v <= n) begin
					cost_mem[(it.vertex_u-1)*NV + it.vertex_v-1] = it.edge_weight;
					cost_mem[(it.vertex_v-1)*NV + it.vertex_u-1] = it.edge_weight;
					edge_on[(it.vertex_u-1)*NV + it.vertex_v-1] = 1'b1;
					edge_on[(it.vertex_v-1)*NV + it.vertex_u-1] = 1'b1;
				end
			end
			mst_pkg::CMD_RUN: begin
				for (int k = 0; k <= NV; k++) forest[k] = '0;
				chosen = 0;
				total = '0;
				while (chosen + 1 < n) begin
					found = 0;
					best = 0; a = 0; b = 0;
					for (int i = 1; i <= n; i++)
						for (int j = 1; j <= n; j++) begin
							idx = (i-1)*NV + j-1;
							if (edge_on[idx] && (!found || cost_mem[idx] < best)) begin
								found = 1;
								best = int'(cost_mem[idx]);
								a = i;
								b = j;
							end
						end
					if (!found) break;
					ra = root_of(a);
					rb = root_of(b);
					if (ra != rb) begin
						forest[rb] = 5'(ra);
						chosen++;
						total = (mst_pkg::SUM_MAX - total < best) ? mst_pkg::SUM_MAX
						        : 22'(total + best);
						r = '0;
						r.is_edge = 1'b1;
						r.from_vertex = 5'(a);
						r.to_vertex = 5'(b);
						r.chosen_weight = 16'(best);
						r.total_weight = total;
						tree_q.push_back(r);
					end
					edge_on[(a-1)*NV + b-1] = 1'b0;
					edge_on[(b-1)*NV + a-1] = 1'b0;
				end
				r = '0;
				r.total_weight = total;
				r.spanning = (chosen + 1 == n);
				r.last = 1'b1;
				tree_q.push_back(r);
			end
			default: ;
		endcase
	endtask

	// called at a rising edge; returns at a rising edge
	task automatic send_cmd(input logic [1:0] c, input logic [4:0] u,
			input logic [4:0] v, input logic [15:0] w);
		mst_pkg::in_t it;
		it.command = c;
		it.vertex_u = u;
		it.vertex_v = v;
		it.edge_weight = w;
		cmd_valid <= 1'b1;
		cmd_data <= it;
		do @(posedge clk); while (!cmd_ready);
		predict_tree(it);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 8);
			if ($urandom_range(0, 2) != 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (tree_q.size() != 0) @(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic write_vcount(input logic [4:0] val);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		vcount = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic add_random(input int n);
		logic [4:0] u, v;
		logic [15:0] w;
		if ($urandom_range(0, 9) == 0) begin
			u = 5'($urandom_range(0, 31));
			v = 5'($urandom_range(0, 31));
		end else begin
			u = 5'($urandom_range(1, n));
			v = 5'($urandom_range(1, n));
		end
		w = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 7)) : 16'($urandom);
		send_cmd(mst_pkg::CMD_ADD, u, v, w);
	endtask

	task automatic test_directed();
		send_cmd(mst_pkg::CMD_CLEAR, 5'd0, 5'd0, 16'd0);
		send_cmd(mst_pkg::CMD_ADD, 5'd1, 5'd16, 16'hFFFF);
		send_cmd(mst_pkg::CMD_ADD, 5'd16, 5'd1, 16'd0);
		send_cmd(mst_pkg::CMD_ADD, 5'd0, 5'd3, 16'd5);
		send_cmd(mst_pkg::CMD_ADD, 5'd17, 5'd2, 16'd5);
		send_cmd(mst_pkg::CMD_ADD, 5'd31, 5'd31, 16'hAAAA);
		send_cmd(mst_pkg::CMD_ADD, 5'd5, 5'd5, 16'd0);
		send_cmd(mst_pkg::CMD_ADD, 5'd2, 5'd3, 16'd9);
		send_cmd(mst_pkg::CMD_ADD, 5'd3, 5'd4, 16'd9);
		send_cmd(mst_pkg::CMD_ADD, 5'd2, 5'd4, 16'd9);
		send_cmd(mst_pkg::CMD_NONE, 5'd2, 5'd5, 16'h5555);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		// full chain of heavy edges
		send_cmd(mst_pkg::CMD_CLEAR, 5'd0, 5'd0, 16'd0);
		for (int k = 1; k < NV; k++)
			send_cmd(mst_pkg::CMD_ADD, 5'(k), 5'(k+1), 16'hFFFF);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		write_vcount(5'd1);
		send_cmd(mst_pkg::CMD_ADD, 5'd1, 5'd1, 16'd3);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		write_vcount(5'd0);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		write_vcount(5'd31);
		send_cmd(mst_pkg::CMD_ADD, 5'd16, 5'd15, 16'd1);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
	endtask

	task automatic test_random();
		int n;
		logic [4:0] setting [0:7];
		setting = '{5'd2, 5'd16, 5'd3, 5'd5, 5'd0, 5'd6, 5'd31, 5'd4};
		for (int p = 0; p < 8; p++) begin
			write_vcount((p == 3) ? 5'($urandom_range(2, 16)) : setting[p]);
			n = eff_n();
			send_cmd(mst_pkg::CMD_CLEAR, 5'($urandom), 5'($urandom), 16'($urandom));
			repeat ($urandom_range(3, 7)) begin
				if ($urandom_range(0, 15) == 0)
					send_cmd(mst_pkg::CMD_NONE, 5'($urandom), 5'($urandom),
						16'($urandom));
				else
					add_random(n);
			end
			send_cmd(mst_pkg::CMD_RUN, 5'($urandom), 5'($urandom), 16'($urandom));
			if ($urandom_range(0, 1) != 0) begin
				add_random(n);
				send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
			end
		end
	endtask

	task automatic test_backpressure();
		write_vcount(5'd8);
		send_cmd(mst_pkg::CMD_CLEAR, 5'd0, 5'd0, 16'd0);
		for (int k = 1; k < 8; k++)
			send_cmd(mst_pkg::CMD_ADD, 5'(k), 5'(k+1), 16'($urandom));
		hold_req = 1;
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		repeat (6) add_random(8);
		send_cmd(mst_pkg::CMD_RUN, 5'd0, 5'd0, 16'd0);
		wait_drained();
	endtask

	// receiver: random stalls alternating with clean stretches, plus one long hold
	initial begin
		int phase;
		phase = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				res_ready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			phase = (phase + 1) % 96;
			if (phase < 32) res_ready <= 1'b1;
			else res_ready <= ($urandom_range(0, 3) != 0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready) begin
			mst_pkg::out_t e;
			if (tree_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", res_data);
			end else begin
				e = tree_q.pop_front();
				if (res_data.is_edge !== e.is_edge || res_data.from_vertex !== e.from_vertex
						|| res_data.to_vertex !== e.to_vertex
						|| res_data.chosen_weight !== e.chosen_weight
						|| res_data.total_weight !== e.total_weight
						|| res_data.spanning !== e.spanning || res_data.last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch exp e%0d %0d-%0d w%0d t%0d s%0d l%0d",
							" got e%0d %0d-%0d w%0d t%0d s%0d l%0d"},
							e.is_edge, e.from_vertex, e.to_vertex, e.chosen_weight,
							e.total_weight, e.spanning, e.last,
							res_data.is_edge, res_data.from_vertex, res_data.to_vertex,
							res_data.chosen_weight, res_data.total_weight,
							res_data.spanning, res_data.last);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("minimum_spanning_tree_engine test failed");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < NV*NV; k++) edge_on[k] = 1'b0;
		for (int k = 0; k <= NV; k++) forest[k] = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_backpressure();
		wait_drained();
		repeat (20) @(posedge clk);
		if (mismatches == 0 && tree_q.size() == 0)
			$display("minimum_spanning_tree_engine test passed");
		else
			$display("minimum_spanning_tree_engine test failed");
		$finish;
	end

endmodule
